// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file mexp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_WAIT,
        ST_SCAN,
        ST_SQR_START,
        ST_SQR_WAIT,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULTIPLY
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        op_t  op;
        logic store_base;
        logic store_acc;
        logic advance;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_msb;
        logic bits_zero;
        logic bits_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
`timescale 1ns / 1ps

interface mexp_in_if #(
    parameter int OPERAND_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 32
);
    logic                      valid;
    logic                      ready;
    logic [OPERAND_WIDTH-1:0]  base;
    logic [EXPONENT_WIDTH-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

// ===== rtl/core/mexp_out_if.sv =====
`timescale 1ns / 1ps

interface mexp_out_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// ===== rtl/core/mexp_mulmod.sv =====
`timescale 1ns / 1ps

// Interleaved shift-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] a,
    input  logic [OPERAND_WIDTH-1:0] b,
    input  logic [OPERAND_WIDTH-1:0] n,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] product
);
    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  p_reg, p_next;

    logic [W+1:0]  t, t_m1, t_m2, n1, n2;
    logic [W-1:0]  step;

    // 2p + bit*a stays below 3n, so at most two subtractions of n.
    always_comb
    begin
        n1   = {2'b00, n};
        n2   = {1'b0, n, 1'b0};
        t    = {1'b0, p_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        t_m1 = t - n1;
        t_m2 = t - n2;
        if (n == '0)
        begin
            step = t[W-1:0];
        end
        else if (t >= n2)
        begin
            step = t_m2[W-1:0];
        end
        else if (t >= n1)
        begin
            step = t_m1[W-1:0];
        end
        else
        begin
            step = t[W-1:0];
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(W);
            a_next   = a;
            b_next   = b;
            p_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            b_next    = {b_reg[W-2:0], 1'b0};
            p_next    = step;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done    = done_reg;
    assign product = p_reg;
endmodule

// ===== rtl/core/mexp_dp.sv =====
`timescale 1ns / 1ps

// Datapath: modulus, operands, exponent scanner, multiplier and result register.
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      modulus_wr_en,
    input  logic [OPERAND_WIDTH-1:0]  modulus_wr_data,
    input  logic [OPERAND_WIDTH-1:0]  base,
    input  logic [EXPONENT_WIDTH-1:0] exponent,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [OPERAND_WIDTH-1:0]  power
);
    localparam int W  = OPERAND_WIDTH;
    localparam int EW = EXPONENT_WIDTH;
    localparam int BW = $clog2(EW + 1);

    logic [W-1:0]  n_reg;
    logic [W-1:0]  base_reg;
    logic [W-1:0]  acc_reg;
    logic [EW-1:0] exp_reg;
    logic [BW-1:0] bits_reg;
    logic          out_valid_reg;
    logic [W-1:0]  power_reg;

    logic [W-1:0]  mul_a, mul_b, product;
    logic          mul_done;

    always_comb
    begin
        unique case (cmd.op)
            OP_REDUCE:
            begin
                mul_a = W'(1);
                mul_b = base_reg;
            end
            OP_SQUARE:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            OP_MULTIPLY:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
        endcase
    end

    mexp_mulmod #(
        .OPERAND_WIDTH(W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .n      (n_reg),
        .done   (mul_done),
        .product(product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (modulus_wr_en)
            begin
                n_reg <= modulus_wr_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base;
            exp_reg  <= exponent;
            bits_reg <= BW'(EW);
            acc_reg  <= W'(1);
        end
        else
        begin
            if (cmd.store_base)
            begin
                base_reg <= product;
            end
            if (cmd.store_acc)
            begin
                acc_reg <= product;
            end
            if (cmd.advance)
            begin
                exp_reg  <= exp_reg << 1;
                bits_reg <= bits_reg - BW'(1);
            end
        end
        if (cmd.emit)
        begin
            power_reg <= acc_reg;
        end
    end

    assign sts.mul_done  = mul_done;
    assign sts.exp_msb   = exp_reg[EW-1];
    assign sts.bits_zero = (bits_reg == '0);
    assign sts.bits_last = (bits_reg == BW'(1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign power     = power_reg;
endmodule

// ===== rtl/core/mexp_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer: reduce base, skip leading zeros, then square per bit and multiply on each one bit.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RED_START;
                end
            end
            ST_RED_START:
            begin
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (sts.bits_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.exp_msb)
                begin
                    state_next = ST_SQR_START;
                end
            end
            ST_SQR_START:
            begin
                state_next = ST_SQR_WAIT;
            end
            ST_SQR_WAIT:
            begin
                if (sts.mul_done)
                begin
                    priority if (sts.exp_msb)
                    begin
                        state_next = ST_MUL_START;
                    end
                    else if (sts.bits_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SQR_START;
                    end
                end
            end
            ST_MUL_START:
            begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = sts.bits_last ? ST_FINISH : ST_SQR_START;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = OP_SQUARE;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RED_START:
            begin
                cmd.op        = OP_REDUCE;
                cmd.mul_start = 1'b1;
            end
            ST_RED_WAIT:
            begin
                cmd.store_base = sts.mul_done;
            end
            ST_SCAN:
            begin
                cmd.advance = !sts.bits_zero && !sts.exp_msb;
            end
            ST_SQR_START:
            begin
                cmd.op        = OP_SQUARE;
                cmd.mul_start = 1'b1;
            end
            ST_SQR_WAIT:
            begin
                cmd.store_acc = sts.mul_done;
                cmd.advance   = sts.mul_done && !sts.exp_msb;
            end
            ST_MUL_START:
            begin
                cmd.op        = OP_MULTIPLY;
                cmd.mul_start = 1'b1;
            end
            ST_MUL_WAIT:
            begin
                cmd.store_acc = sts.mul_done;
                cmd.advance   = sts.mul_done;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// ===== rtl/core/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Handshake      Payload
// in_ch     in    valid/ready    base, exponent  (one request per power)
// out_ch    out   valid/ready    power
// modulus   in    modulus_wr_en  modulus_wr_data (no read-back)
//
// Order of work: reduce the base, skip the leading zero exponent bits, then
// square on every remaining bit and also multiply on each one bit, and last
// post the result. The run time is set by the single shift-add modular
// multiplier, one bit/cycle. Reset puts the modulus at 2 and the sequencer
// idle with no result pending. A waiting result holds in the output
// register; the next request is taken meanwhile, and the sequencer only
// stalls at the end if that result is unread.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     modulus_wr_en,
    input  logic [OPERAND_WIDTH-1:0] modulus_wr_data,
    mexp_in_if.sink                  in_ch,
    mexp_out_if.source               out_ch
);
    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    // Sequencer: decides the order of reduce, square and multiply steps.
    mexp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: holds modulus and operands, runs the modular multiplier.
    mexp_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .EXPONENT_WIDTH(EXPONENT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .modulus_wr_en  (modulus_wr_en),
        .modulus_wr_data(modulus_wr_data),
        .base           (in_ch.base),
        .exponent       (in_ch.exponent),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .power          (out_ch.power)
    );

    assign in_ch.ready = in_ready;
endmodule

// ===== rtl/core/mexp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [OPERAND_WIDTH-1:0] power
);
    // A taken request keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
    // A fresh result is posted only as the sequencer goes back to idle.
    `ASSERT_IMPL(a_idle_on_result, clk, rst_n, $rose(out_valid), in_ready)
    // A stalled result holds its value.
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(power))
endmodule

bind modular_exponentiation mexp_checker #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
) u_mexp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .power    (out_ch.power)
);

// ===== sim/power_monitor.sv =====
`timescale 1ns / 1ps

module power_monitor #(
    parameter int OPERAND_WIDTH  = 32,
    parameter int EXPONENT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     modulus_wr_en,
    input  logic [OPERAND_WIDTH-1:0] modulus_wr_data,
    mexp_in_if                       in_ch,
    mexp_out_if                      out_ch,
    output int                       mismatch_count,
    output int                       outstanding
);

    typedef logic [OPERAND_WIDTH-1:0]   word_t;
    typedef logic [2*OPERAND_WIDTH-1:0] wide_t;

    localparam int    MAX_REPORTS   = 10;
    localparam word_t RESET_MODULUS = word_t'(2);

    word_t modulus_q;
    word_t expected_powers[$];
    word_t expected;
    int    errors;

    // Modulus zero stands for 2^OPERAND_WIDTH: keep the low bits of the product.
    function automatic word_t mul_reduce(word_t a, word_t b, word_t n);
        wide_t product;
        product = wide_t'(a) * wide_t'(b);
        if (n == '0)
            return word_t'(product);
        return word_t'(product % wide_t'(n));
    endfunction

    function automatic word_t predict_power(word_t b, logic [EXPONENT_WIDTH-1:0] e,
                                            word_t n);
        word_t acc;
        word_t base_red;
        bit    seen;
        acc      = word_t'(1);
        seen     = 1'b0;
        base_red = (n == '0) ? b : b % n;
        for (int i = EXPONENT_WIDTH - 1; i >= 0; i--)
        begin
            if (e[i] || seen)
            begin
                // Reduce the starting one on the leading set bit.
                if (!seen && n != '0)
                    acc = acc % n;
                seen = 1'b1;
                acc  = mul_reduce(acc, acc, n);
                if (e[i])
                    acc = mul_reduce(acc, base_red, n);
            end
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q = RESET_MODULUS;
            expected_powers.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // Retire results before queuing new requests taken at the same edge.
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("power_monitor: unexpected power %h", out_ch.power);
                end
                else
                begin
                    expected = expected_powers.pop_front();
                    if (out_ch.power !== expected)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("power_monitor: power expected %h got %h",
                                     expected, out_ch.power);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_powers.push_back(predict_power(in_ch.base, in_ch.exponent,
                                                        modulus_q));
            if (modulus_wr_en)
                modulus_q = modulus_wr_data;
            mismatch_count <= errors;
            outstanding    <= expected_powers.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int OPERAND_WIDTH  = 32;
    localparam int EXPONENT_WIDTH = 32;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int IDLE_PERCENT   = 12;
    // A full-width request still in flight, then a held result plus one more
    // short request, stall the input well inside this.
    localparam int HOLDOFF_CYCLES = 6000;
    // Watch a while after the queue empties for stray results.
    localparam int DRAIN_CYCLES   = 200;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 40;
    localparam int CALM_FIRST     = 120;
    localparam int CALM_LAST      = 179;
    localparam int HOLDOFF_ITEM   = 20;

    logic                     clk;
    logic                     rst_n;
    logic                     modulus_wr_en;
    logic [OPERAND_WIDTH-1:0] modulus_wr_data;

    int                       mismatch_count;
    int                       outstanding;

    // calm: both sides stop idling. holdoff_*: handshake with the receiver process.
    bit                       calm;
    bit                       holdoff_armed;
    bit                       holdoff_taken;
    logic [OPERAND_WIDTH-1:0] modulus_now;
    logic [OPERAND_WIDTH-1:0] phase_moduli [PHASES];
    int                       item_count;

    mexp_in_if #(
        .OPERAND_WIDTH  (OPERAND_WIDTH),
        .EXPONENT_WIDTH (EXPONENT_WIDTH)
    ) in_ch ();

    mexp_out_if #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) out_ch ();

    modular_exponentiation #(
        .OPERAND_WIDTH  (OPERAND_WIDTH),
        .EXPONENT_WIDTH (EXPONENT_WIDTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch)
    );

    power_monitor #(
        .OPERAND_WIDTH  (OPERAND_WIDTH),
        .EXPONENT_WIDTH (EXPONENT_WIDTH)
    ) u_power_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Stop a hung run: count cycles and give up well past the slowest good run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: drop ready at random, hold it low for a long stretch once,
    // and keep it high while the calm stretch runs.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_armed && !holdoff_taken)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_taken = 1'b1;
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one request and hold it until the block takes it. Valid stays high
    // on return so back-to-back requests need no bubble.
    task automatic send_request(input logic [OPERAND_WIDTH-1:0]  b,
                                input logic [EXPONENT_WIDTH-1:0] e);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.base     <= b;
        in_ch.exponent <= e;
        do
            @(posedge clk);
        while (!in_ch.ready);
        item_count++;
    endtask

    // Drop valid and wait for every predicted power to come back. Each request
    // yields exactly one result, so an empty queue means the block is idle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_modulus(input logic [OPERAND_WIDTH-1:0] value);
        wait_drained();
        modulus_wr_en   <= 1'b1;
        modulus_wr_data <= value;
        @(posedge clk);
        modulus_wr_en   <= 1'b0;
        modulus_now = value;
    endtask

    // Mix full-width exponents with short ones to keep the run time down;
    // short_only keeps requests quick while the result side is held off.
    function automatic logic [EXPONENT_WIDTH-1:0] random_exponent(input bit short_only);
        int unsigned pick;
        int unsigned span;
        if (short_only)
            return $urandom & ((32'd1 << $urandom_range(4, 1)) - 32'd1);
        pick = $urandom_range(9);
        span = $urandom_range(32, 1);
        case (pick)
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom & ((32'd1 << $urandom_range(12, 1)) - 32'd1);
            7:          return $urandom | 32'h8000_0000;
            8:          return '0;
            default:    return $urandom >> (32 - span);
        endcase
    endfunction

    // Hit the edges of the reduction: small values, all ones, and values near the modulus.
    function automatic logic [OPERAND_WIDTH-1:0] random_base();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            6:       return $urandom_range(15);
            7:       return '1;
            8:       return modulus_now;
            9:       return modulus_now - 1'b1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.base      <= '0;
        in_ch.exponent  <= '0;
        modulus_wr_en   <= 1'b0;
        modulus_wr_data <= '0;
        calm          = 1'b0;
        holdoff_armed = 1'b0;
        holdoff_taken = 1'b0;
        modulus_now   = 32'd2;
        item_count    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus of two: zero exponent, exponent one, all ones, base equal to it.
        send_request(32'd0, 32'd0);
        send_request(32'd5, 32'd0);
        send_request(32'd3, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd2, 32'd5);

        // Largest modulus: base equal to it, base zero, lone top exponent bit.
        set_modulus(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'd0, 32'd5);
        send_request(32'd0, 32'd0);
        send_request(32'd2, 32'd31);
        send_request(32'd7, 32'h8000_0000);

        // Modulus one: zero exponent still gives one, anything else gives zero.
        set_modulus(32'd1);
        send_request(32'd5, 32'd0);
        send_request(32'd5, 32'd3);

        // Modulus zero wraps at the word width.
        set_modulus(32'd0);
        send_request(32'hFFFF_FFFF, 32'd2);
        send_request(32'd3, 32'hFFFF_FFFF);
        send_request(32'h0001_0000, 32'd2);

        // Small prime: base above the modulus must be reduced first.
        set_modulus(32'd97);
        send_request(32'd100, 32'd96);
        send_request(32'd96, 32'd1);

        phase_moduli[0] = 32'hFFFF_FFFF;
        phase_moduli[1] = $urandom | 32'h8000_0001;
        phase_moduli[2] = 32'd2;
        phase_moduli[3] = 32'd0;
        phase_moduli[4] = $urandom_range(1000, 3);
        phase_moduli[5] = 32'd1;
        phase_moduli[6] = $urandom;

        item_count = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_modulus(phase_moduli[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                calm = (item_count >= CALM_FIRST) && (item_count <= CALM_LAST);
                if (item_count == HOLDOFF_ITEM)
                    holdoff_armed = 1'b1;
                send_request(random_base(),
                             random_exponent(holdoff_armed && !holdoff_taken));
            end
        end
        calm = 1'b0;

        // Let every result land, then watch a while for stray ones.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_out_if.sv
rtl/core/mexp_mulmod.sv
rtl/core/mexp_dp.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation.sv
rtl/core/mexp_checker.sv
sim/power_monitor.sv
sim/tb_top.sv
